// ----- rtl/vob_pkg.sv -----
package vob_pkg;

    // block side used when the top level is not overridden
    localparam int BLOCK_SIDE = 8;

    // fixed field widths
    localparam int COORD_W = 4;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 10;
    localparam int DIM_W   = 2;

    // dimensions register
    localparam logic [DIM_W-1:0] DIM_FLAT  = 2'd2;
    localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;

    // commands
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_BUSY  = 2'd1,
        ST_FULL  = 2'd2
    } node_state_t;

endpackage

// ----- rtl/vob_if.sv -----
interface vob_req_if;
    logic                      valid;
    logic                      ready;
    logic [vob_pkg::CMD_W-1:0]   cmd;
    logic [vob_pkg::COORD_W-1:0] coord_x;
    logic [vob_pkg::COORD_W-1:0] coord_y;
    logic [vob_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, output cmd, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input cmd, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

interface vob_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      cell_is_set;
    logic [vob_pkg::COUNT_W-1:0] set_count;
    logic [1:0]                node_state;
    logic                      coord_error;

    modport source (output valid, output cell_is_set, output set_count,
                    output node_state, output coord_error, input ready);
    modport sink   (input valid, input cell_is_set, input set_count,
                    input node_state, input coord_error, output ready);
endinterface

interface vob_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [vob_pkg::DIM_W-1:0] dimensions;

    modport source (output valid, output dimensions, input ready);
    modport sink   (input valid, input dimensions, output ready);
endinterface

// ----- rtl/vob_ram.sv -----
module vob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/voxel_occupancy_block_top.sv -----
// channel  dir  word                                         handshake
// req      in   cmd, coord_x, coord_y, coord_z               valid / ready
// rsp      out  cell_is_set, set_count, node_state, coord_error valid / ready
// cfg      in   dimensions (write also clears the block)     valid / ready (always ready)
//
// one word per cycle sustained while rsp is ready; a result passes the stage and result registers
// the cell store is a ram of side*side rows, one bit per x; its registered read
// sets the extra stage, and a write from the stage is forwarded to the next word
// per-row valid flops clear the whole block at once, on reset, clear or cfg
// a stalled rsp holds the stage and the ram read register; req.ready drops
module voxel_occupancy_block_top #(
    parameter int BLOCK_SIDE = vob_pkg::BLOCK_SIDE
) (
    input  logic      clk,
    input  logic      rst_n,
    vob_req_if.sink   req,
    vob_rsp_if.source rsp,
    vob_cfg_if.sink   cfg
);

    localparam int ROWS   = BLOCK_SIDE * BLOCK_SIDE;
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(BLOCK_SIDE);
    localparam int CNT_W  = $clog2(BLOCK_SIDE * BLOCK_SIDE * BLOCK_SIDE + 1);
    localparam int CALC_W = 2 * vob_pkg::COORD_W + 1;
    localparam int CMP_W  = vob_pkg::COORD_W + 1;
    localparam logic [CNT_W-1:0] CELLS_2D = CNT_W'(ROWS);
    localparam logic [CNT_W-1:0] CELLS_3D = CNT_W'(ROWS * BLOCK_SIDE);

    // control state
    logic [vob_pkg::DIM_W-1:0] dims_reg, dims_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    vob_pkg::node_state_t      state_reg, state_next;
    logic [ROWS-1:0]           row_valid_reg, row_valid_next;
    logic                      s1_valid_reg;
    logic                      res_valid_reg;

    // stage payload
    logic [vob_pkg::CMD_W-1:0]   s1_cmd_reg;
    logic [vob_pkg::COORD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [RW-1:0]               s1_row_reg;
    logic                        fwd_hit_reg, fwd_hit_next;
    logic [BLOCK_SIDE-1:0]       fwd_data_reg;

    // result payload
    logic                        res_answer_reg;
    logic [vob_pkg::COUNT_W-1:0] res_count_reg;
    logic [1:0]                  res_state_reg;
    logic                        res_error_reg;

    logic                        flat;
    logic                        advance;
    logic                        commit;
    logic                        cfg_wr;
    logic [vob_pkg::COORD_W-1:0] in_z;
    logic [CALC_W-1:0]           in_row_calc;
    logic [RW-1:0]               in_row;
    logic [BLOCK_SIDE-1:0]       ram_rdata;
    logic [BLOCK_SIDE-1:0]       row_data;
    logic [BLOCK_SIDE-1:0]       col_mask;
    logic [BLOCK_SIDE-1:0]       wr_data;
    logic                        cell_bit;
    logic                        coord_bad;
    logic [CNT_W-1:0]            cells_in_use;
    logic [CNT_W-1:0]            count_inc;
    logic [CNT_W-1:0]            item_count;
    vob_pkg::node_state_t        item_state;
    logic                        item_clear;
    logic                        item_answer;
    logic                        item_error;
    logic                        item_write;
    logic                        ram_we;
    logic [CNT_W+vob_pkg::COUNT_W-1:0] count_wide;

    assign flat    = (dims_reg == vob_pkg::DIM_FLAT);
    assign advance = !res_valid_reg || rsp.ready;
    assign commit  = s1_valid_reg && advance;
    assign cfg_wr  = cfg.valid && cfg.ready;

    assign req.ready = advance;
    assign cfg.ready = 1'b1;

    // row address of the incoming word, z dropped in two dimensions
    assign in_z        = flat ? '0 : req.coord_z;
    assign in_row_calc = CALC_W'(req.coord_y) + CALC_W'(in_z) * CALC_W'(BLOCK_SIDE);
    assign in_row      = in_row_calc[RW-1:0];

    vob_ram #(
        .WIDTH (BLOCK_SIDE),
        .DEPTH (ROWS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_row_reg),
        .wdata (wr_data),
        .re    (advance),
        .raddr (in_row),
        .rdata (ram_rdata)
    );

    // stage evaluation
    assign row_data = fwd_hit_reg ? fwd_data_reg
                    : (row_valid_reg[s1_row_reg] ? ram_rdata : '0);
    assign col_mask = {{(BLOCK_SIDE-1){1'b0}}, 1'b1} << s1_x_reg[CW-1:0];
    assign cell_bit = |(row_data & col_mask);
    assign wr_data  = row_data | col_mask;

    assign coord_bad = (CMP_W'(s1_x_reg) >= CMP_W'(BLOCK_SIDE))
                    || (CMP_W'(s1_y_reg) >= CMP_W'(BLOCK_SIDE))
                    || (CMP_W'(s1_z_reg) >= CMP_W'(BLOCK_SIDE));

    assign cells_in_use = flat ? CELLS_2D : CELLS_3D;
    assign count_inc    = count_reg + CNT_W'(1);

    // block state and count after the staged word
    always_comb
    begin
        item_count = count_reg;
        item_state = state_reg;
        item_clear = 1'b0;
        unique case (s1_cmd_reg)
            vob_pkg::CMD_SET:
            begin
                if (!coord_bad && state_reg != vob_pkg::ST_FULL)
                begin
                    item_state = vob_pkg::ST_BUSY;
                    if (!cell_bit)
                    begin
                        item_count = count_inc;
                    end
                    if (item_count >= cells_in_use)
                    begin
                        item_state = vob_pkg::ST_FULL;
                    end
                end
            end
            vob_pkg::CMD_CLEAR:
            begin
                item_count = '0;
                item_state = vob_pkg::ST_EMPTY;
                item_clear = 1'b1;
            end
            vob_pkg::CMD_TEST, vob_pkg::CMD_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // answer, error and store write of the staged word
    always_comb
    begin
        item_answer = 1'b0;
        item_error  = 1'b0;
        item_write  = 1'b0;
        unique case (s1_cmd_reg)
            vob_pkg::CMD_SET:
            begin
                if (coord_bad)
                begin
                    item_error = 1'b1;
                end
                else if (state_reg != vob_pkg::ST_FULL && !cell_bit)
                begin
                    item_write = 1'b1;
                end
            end
            vob_pkg::CMD_TEST:
            begin
                if (coord_bad)
                begin
                    item_error = 1'b1;
                end
                else if (state_reg == vob_pkg::ST_FULL)
                begin
                    item_answer = 1'b1;
                end
                else if (state_reg == vob_pkg::ST_BUSY)
                begin
                    item_answer = cell_bit;
                end
            end
            vob_pkg::CMD_CLEAR, vob_pkg::CMD_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign ram_we = commit && item_write;

    // the ram read issued now misses a write landing on the same row
    assign fwd_hit_next = ram_we && (in_row == s1_row_reg);

    assign count_wide = {{vob_pkg::COUNT_W{1'b0}}, item_count};

    always_comb
    begin
        dims_next      = dims_reg;
        count_next     = count_reg;
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        if (cfg_wr)
        begin
            dims_next      = cfg.dimensions;
            count_next     = '0;
            state_next     = vob_pkg::ST_EMPTY;
            row_valid_next = '0;
        end
        else if (commit)
        begin
            count_next = item_count;
            state_next = item_state;
            if (item_clear)
            begin
                row_valid_next = '0;
            end
            else if (item_write)
            begin
                row_valid_next[s1_row_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg      <= vob_pkg::DIM_RESET;
            count_reg     <= '0;
            state_reg     <= vob_pkg::ST_EMPTY;
            row_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            dims_reg      <= dims_next;
            count_reg     <= count_next;
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            if (advance)
            begin
                s1_valid_reg  <= req.valid;
                res_valid_reg <= s1_valid_reg;
                fwd_hit_reg   <= fwd_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cmd_reg     <= req.cmd;
            s1_x_reg       <= req.coord_x;
            s1_y_reg       <= req.coord_y;
            s1_z_reg       <= in_z;
            s1_row_reg     <= in_row;
            fwd_data_reg   <= wr_data;
            res_answer_reg <= item_answer;
            res_count_reg  <= count_wide[vob_pkg::COUNT_W-1:0];
            res_state_reg  <= item_state;
            res_error_reg  <= item_error;
        end
    end

    assign rsp.valid       = res_valid_reg;
    assign rsp.cell_is_set = res_answer_reg;
    assign rsp.set_count   = res_count_reg;
    assign rsp.node_state  = res_state_reg;
    assign rsp.coord_error = res_error_reg;

endmodule
